FILE: hw/rtl/oled_controller_command_decoder_macros.svh
// Assertion macros for the OLED controller command decoder.
`ifndef OLED_CONTROLLER_COMMAND_DECODER_MACROS_SVH
`define OLED_CONTROLLER_COMMAND_DECODER_MACROS_SVH

// Same-cycle implication under reset.
`define OLEDCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define OLEDCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/oledcd_pkg.sv
// Package with opcodes, effect codes and reset values of the OLED command decoder.
package oledcd_pkg;

    localparam int COLUMNS = 132;
    localparam int PAGES   = 8;

    localparam logic [8:0] COLUMNS_W   = 9'(COLUMNS);
    localparam logic [8:0] LAST_COL_W  = 9'(COLUMNS - 1);
    localparam logic [3:0] PAGES_W     = 4'(PAGES);
    localparam logic [2:0] LAST_PAGE   = 3'(PAGES - 1);

    typedef enum logic [1:0] {
        EFF_CTRL = 2'd0,
        EFF_RAM  = 2'd1,
        EFF_CMD  = 2'd2,
        EFF_BAD  = 2'd3
    } effect_t;

    localparam logic [7:0] CTRL_CO = 8'h80;
    localparam logic [7:0] CTRL_DC = 8'h40;

    localparam logic [7:0] OP_CONTRAST = 8'h81;
    localparam logic [7:0] OP_MUX      = 8'hA8;
    localparam logic [7:0] OP_DCDC     = 8'hAD;
    localparam logic [7:0] OP_OFFSET   = 8'hD3;
    localparam logic [7:0] OP_CLOCK    = 8'hD5;
    localparam logic [7:0] OP_CHARGE   = 8'hD9;
    localparam logic [7:0] OP_COMPINS  = 8'hDA;
    localparam logic [7:0] OP_VCOM     = 8'hDB;
    localparam logic [7:0] OP_SEG0     = 8'hA0;
    localparam logic [7:0] OP_SEG1     = 8'hA1;
    localparam logic [7:0] OP_ALLON0   = 8'hA4;
    localparam logic [7:0] OP_ALLON1   = 8'hA5;
    localparam logic [7:0] OP_NORMAL   = 8'hA6;
    localparam logic [7:0] OP_INVERSE  = 8'hA7;
    localparam logic [7:0] OP_OFF      = 8'hAE;
    localparam logic [7:0] OP_ON       = 8'hAF;
    localparam logic [7:0] OP_PAGE     = 8'hB0;
    localparam logic [7:0] OP_PUMP     = 8'h30;
    localparam logic [7:0] OP_RMW      = 8'hE0;
    localparam logic [7:0] OP_NOP      = 8'hE3;
    localparam logic [7:0] OP_END      = 8'hEE;

    localparam int F_ON     = 0;
    localparam int F_INV    = 1;
    localparam int F_ALLON  = 2;
    localparam int F_SEG    = 3;
    localparam int F_COMREV = 4;
    localparam int F_DCDC   = 5;
    localparam int F_COMALT = 6;
    localparam int F_RMW    = 7;
    localparam int F_PUMP   = 8;

    localparam logic [7:0] RST_CONTRAST = 8'h80;
    localparam logic [5:0] RST_MUX      = 6'd63;
    localparam logic [9:0] RST_MODE     = 10'h260;
    localparam logic [7:0] RST_CLOCK    = 8'h50;
    localparam logic [7:0] RST_CHARGE   = 8'h22;
    localparam logic [7:0] RST_VCOM     = 8'h35;

    function automatic logic is_double(input logic [7:0] op);
        return op == OP_CONTRAST || op == OP_MUX || op == OP_DCDC || op == OP_OFFSET ||
               op == OP_CLOCK || op == OP_CHARGE || op == OP_COMPINS || op == OP_VCOM;
    endfunction

endpackage

FILE: hw/rtl/oled_controller_command_decoder.sv
// OLED controller command decoder: control, command and RAM-data byte decode.
// Usage:
//   Input channel in_valid/in_stall carries one I2C payload byte (bus_byte) and
//   first_byte, set on the byte that opens a write transaction. Output channel
//   out_valid/out_stall carries one result item per input item: effect, the
//   RAM write page/column/data, and all display settings after that byte.
//   Each byte passes the input register, then the result register.
//   Throughput: one item per cycle while the receiver does not stall; the
//   decode runs in one pass between the input and result registers, and the
//   decoder state updates when an item moves into the result register.
//   When the receiver stalls, the result holds and one more item waits in the
//   input register; in_stall rises only when that register is also full.
//   Reset clears both stages and restores the power-on settings: contrast 0x80,
//   mux 63, clock 0x50, charge 0x22, vcom 0x35, dcdc and com alt set, pump 2,
//   page and column 0, and the next byte taken as a control byte.
`include "oled_controller_command_decoder_macros.svh"

module oled_controller_command_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          bus_byte,
    input  logic                first_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output oledcd_pkg::effect_t effect,
    output logic [2:0]          ram_page,
    output logic [7:0]          ram_column,
    output logic [7:0]          ram_data,
    output logic [7:0]          contrast_level,
    output logic [5:0]          start_line,
    output logic [5:0]          display_offset,
    output logic [5:0]          mux_ratio,
    output logic [9:0]          mode_flags,
    output logic [7:0]          clock_setting,
    output logic [7:0]          charge_periods,
    output logic [7:0]          vcom_level
);
    import oledcd_pkg::*;

    logic       in_full_reg;
    logic [7:0] byte_reg;
    logic       first_reg;
    logic       in_accept;
    logic       advance;

    logic       out_valid_reg;
    effect_t    effect_reg, effect_next;
    logic [7:0] wcol_reg, wcol_next;
    logic [7:0] wdata_reg, wdata_next;

    logic       expect_ctrl_reg, expect_ctrl_next;
    logic       is_data_reg, is_data_next;
    logic       single_reg, single_next;
    logic [7:0] pend_op_reg, pend_op_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [2:0] page_reg, page_next;
    logic [7:0] column_reg, column_next;
    logic [7:0] saved_col_reg, saved_col_next;
    logic [7:0] contrast_reg, contrast_next;
    logic [5:0] start_reg, start_next;
    logic [5:0] offset_reg, offset_next;
    logic [5:0] mux_reg, mux_next;
    logic [9:0] mode_reg, mode_next;
    logic [7:0] clock_reg, clock_next;
    logic [7:0] charge_reg, charge_next;
    logic [7:0] vcom_reg, vcom_next;

    assign advance   = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg  <= bus_byte;
            first_reg <= first_byte;
        end
    end

    always_comb
    begin
        logic [3:0] page_sel;
        expect_ctrl_next = expect_ctrl_reg;
        is_data_next     = is_data_reg;
        single_next      = single_reg;
        pend_op_next     = pend_op_reg;
        pend_valid_next  = pend_valid_reg;
        page_next        = page_reg;
        column_next      = column_reg;
        saved_col_next   = saved_col_reg;
        contrast_next    = contrast_reg;
        start_next       = start_reg;
        offset_next      = offset_reg;
        mux_next         = mux_reg;
        mode_next        = mode_reg;
        clock_next       = clock_reg;
        charge_next      = charge_reg;
        vcom_next        = vcom_reg;
        effect_next      = EFF_CMD;
        wdata_next       = 8'd0;
        page_sel         = {1'b0, byte_reg[2:0]};

        if (first_reg || expect_ctrl_reg)
        begin
            single_next      = (byte_reg & CTRL_CO) != 8'd0;
            is_data_next     = (byte_reg & CTRL_DC) != 8'd0;
            expect_ctrl_next = 1'b0;
            effect_next      = EFF_CTRL;
        end
        else
        begin
            if (is_data_reg)
            begin
                if ({1'b0, column_reg} >= COLUMNS_W)
                begin
                    effect_next = EFF_BAD;
                end
                else
                begin
                    wdata_next  = byte_reg;
                    effect_next = EFF_RAM;
                    if ({1'b0, column_reg} < LAST_COL_W)
                    begin
                        column_next = column_reg + 8'd1;
                    end
                end
            end
            else if (pend_valid_reg)
            begin
                pend_valid_next = 1'b0;
                unique case (pend_op_reg)
                    OP_CONTRAST: contrast_next = byte_reg;
                    OP_MUX:      mux_next = byte_reg[5:0];
                    OP_DCDC:     mode_next[F_DCDC] = byte_reg[0];
                    OP_OFFSET:   offset_next = byte_reg[5:0];
                    OP_CLOCK:    clock_next = byte_reg;
                    OP_CHARGE:   charge_next = byte_reg;
                    OP_COMPINS:  mode_next[F_COMALT] = byte_reg[4];
                    default:     vcom_next = byte_reg;
                endcase
            end
            else
            begin
                priority if (byte_reg[7:4] == 4'h0)
                begin
                    column_next = {column_reg[7:4], byte_reg[3:0]};
                end
                else if (byte_reg[7:4] == 4'h1)
                begin
                    column_next = {byte_reg[3:0], column_reg[3:0]};
                end
                else if (byte_reg[7:2] == OP_PUMP[7:2])
                begin
                    mode_next[F_PUMP +: 2] = byte_reg[1:0];
                end
                else if (byte_reg[7:6] == 2'b01)
                begin
                    start_next = byte_reg[5:0];
                end
                else if (is_double(byte_reg))
                begin
                    pend_op_next    = byte_reg;
                    pend_valid_next = 1'b1;
                end
                else if (byte_reg == OP_SEG0 || byte_reg == OP_SEG1)
                begin
                    mode_next[F_SEG] = byte_reg[0];
                end
                else if (byte_reg == OP_ALLON0 || byte_reg == OP_ALLON1)
                begin
                    mode_next[F_ALLON] = byte_reg[0];
                end
                else if (byte_reg == OP_NORMAL || byte_reg == OP_INVERSE)
                begin
                    mode_next[F_INV] = byte_reg[0];
                end
                else if (byte_reg == OP_OFF || byte_reg == OP_ON)
                begin
                    mode_next[F_ON] = byte_reg[0];
                end
                else if (byte_reg[7:3] == OP_PAGE[7:3])
                begin
                    page_next = (page_sel >= PAGES_W) ? LAST_PAGE : byte_reg[2:0];
                end
                else if (byte_reg[7:4] == 4'hC)
                begin
                    mode_next[F_COMREV] = byte_reg[3];
                end
                else if (byte_reg == OP_RMW)
                begin
                    saved_col_next   = column_reg;
                    mode_next[F_RMW] = 1'b1;
                end
                else if (byte_reg == OP_END)
                begin
                    if (mode_reg[F_RMW])
                    begin
                        column_next      = saved_col_reg;
                        mode_next[F_RMW] = 1'b0;
                    end
                end
                else if (byte_reg == OP_NOP)
                begin
                    effect_next = EFF_CMD;
                end
                else
                begin
                    effect_next = EFF_BAD;
                end
            end
            if (single_reg)
            begin
                expect_ctrl_next = 1'b1;
            end
        end

        wcol_next = (effect_next == EFF_RAM) ? column_reg : column_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            effect_reg      <= EFF_CTRL;
            wcol_reg        <= 8'd0;
            wdata_reg       <= 8'd0;
            expect_ctrl_reg <= 1'b1;
            is_data_reg     <= 1'b0;
            single_reg      <= 1'b0;
            pend_op_reg     <= 8'd0;
            pend_valid_reg  <= 1'b0;
            page_reg        <= 3'd0;
            column_reg      <= 8'd0;
            saved_col_reg   <= 8'd0;
            contrast_reg    <= RST_CONTRAST;
            start_reg       <= 6'd0;
            offset_reg      <= 6'd0;
            mux_reg         <= RST_MUX;
            mode_reg        <= RST_MODE;
            clock_reg       <= RST_CLOCK;
            charge_reg      <= RST_CHARGE;
            vcom_reg        <= RST_VCOM;
        end
        else if (advance)
        begin
            out_valid_reg   <= 1'b1;
            effect_reg      <= effect_next;
            wcol_reg        <= wcol_next;
            wdata_reg       <= wdata_next;
            expect_ctrl_reg <= expect_ctrl_next;
            is_data_reg     <= is_data_next;
            single_reg      <= single_next;
            pend_op_reg     <= pend_op_next;
            pend_valid_reg  <= pend_valid_next;
            page_reg        <= page_next;
            column_reg      <= column_next;
            saved_col_reg   <= saved_col_next;
            contrast_reg    <= contrast_next;
            start_reg       <= start_next;
            offset_reg      <= offset_next;
            mux_reg         <= mux_next;
            mode_reg        <= mode_next;
            clock_reg       <= clock_next;
            charge_reg      <= charge_next;
            vcom_reg        <= vcom_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign effect         = effect_reg;
    assign ram_page       = page_reg;
    assign ram_column     = wcol_reg;
    assign ram_data       = wdata_reg;
    assign contrast_level = contrast_reg;
    assign start_line     = start_reg;
    assign display_offset = offset_reg;
    assign mux_ratio      = mux_reg;
    assign mode_flags     = mode_reg;
    assign clock_setting  = clock_reg;
    assign charge_periods = charge_reg;
    assign vcom_level     = vcom_reg;

    `OLEDCD_ASSERT_NOW(a_ram_col_in_range, clk, rst_n, out_valid && effect == EFF_RAM, ({1'b0, ram_column} < COLUMNS_W), "RAM write outside the column range")
    `OLEDCD_ASSERT_NOW(a_data_only_on_write, clk, rst_n, out_valid && effect != EFF_RAM, ram_data == 8'd0, "RAM data set without a RAM write")
    `OLEDCD_ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance, out_valid, "decoded item did not reach the result register")
    `OLEDCD_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, in_full_reg && out_valid_reg && out_stall, "input stalled with room to take an item")

endmodule

FILE: dv/oled_controller_command_decoder_tb.sv
// Self-checking testbench for the OLED command decoder: byte stream in, decoded state out.
`timescale 1ns / 100ps

module oled_controller_command_decoder_tb;
    import oledcd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 950;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int DIRECTED_ROWS = 26;

    typedef struct {
        effect_t     effect;
        logic [2:0]  page;
        logic [7:0]  column;
        logic [7:0]  data;
        logic [7:0]  contrast;
        logic [5:0]  start;
        logic [5:0]  offset;
        logic [5:0]  mux;
        logic [9:0]  mode;
        logic [7:0]  clock;
        logic [7:0]  charge;
        logic [7:0]  vcom;
    } decoded_t;

    typedef struct packed {
        logic [7:0] code;
        logic       opens;
        logic       pinned;
        effect_t    eff;
    } stim_row_t;

    typedef enum int {
        PICK_COL_LO, PICK_COL_HI, PICK_PUMP, PICK_START, PICK_DOUBLE, PICK_MODE,
        PICK_PAGE, PICK_SCAN, PICK_RMW, PICK_ANY, PICK_GAP
    } cmd_pick_t;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  bus_byte;
    logic        first_byte;
    logic        out_valid;
    logic        out_stall;
    effect_t     effect;
    logic [2:0]  ram_page;
    logic [7:0]  ram_column;
    logic [7:0]  ram_data;
    logic [7:0]  contrast_level;
    logic [5:0]  start_line;
    logic [5:0]  display_offset;
    logic [5:0]  mux_ratio;
    logic [9:0]  mode_flags;
    logic [7:0]  clock_setting;
    logic [7:0]  charge_periods;
    logic [7:0]  vcom_level;

    // decoder image
    logic        need_control;
    logic        data_stream;
    logic        co_single;
    logic [7:0]  held_op;
    logic        held_arg;
    logic [2:0]  page_q;
    logic [7:0]  col_q;
    logic [7:0]  col_saved;
    logic [7:0]  contrast_q;
    logic [5:0]  start_q;
    logic [5:0]  offset_q;
    logic [5:0]  mux_q;
    logic [9:0]  mode_q;
    logic [7:0]  clock_q;
    logic [7:0]  charge_q;
    logic [7:0]  vcom_q;

    decoded_t    results_due[$];
    int          errors;
    int          cycle_count;
    int          items_sent;
    int          burst_left;
    int          gap_left;
    int          hold_asked;
    int          hold_served;
    logic        arg_due;

    logic [7:0]  arg_ops  [8] = '{OP_CONTRAST, OP_MUX, OP_DCDC, OP_OFFSET,
                                  OP_CLOCK, OP_CHARGE, OP_COMPINS, OP_VCOM};
    logic [7:0]  mode_ops [8] = '{OP_SEG0, OP_SEG1, OP_ALLON0, OP_ALLON1,
                                  OP_NORMAL, OP_INVERSE, OP_OFF, OP_ON};
    logic [7:0]  rmw_ops  [3] = '{OP_RMW, OP_END, OP_NOP};

    stim_row_t   directed_rows [DIRECTED_ROWS] = '{
        '{8'h00,                1'b1, 1'b1, EFF_CTRL},
        '{OP_ON,                1'b0, 1'b0, EFF_CMD},
        '{OP_INVERSE,           1'b0, 1'b0, EFF_CMD},
        '{OP_CONTRAST,          1'b0, 1'b0, EFF_CMD},
        '{8'hFF,                1'b0, 1'b0, EFF_CMD},
        '{OP_MUX,               1'b0, 1'b0, EFF_CMD},
        '{8'h00,                1'b0, 1'b0, EFF_CMD},
        '{8'h1F,                1'b0, 1'b0, EFF_CMD},
        '{8'h0F,                1'b0, 1'b0, EFF_CMD},
        '{OP_RMW,               1'b0, 1'b0, EFF_CMD},
        '{8'h18,                1'b0, 1'b0, EFF_CMD},
        '{8'h03,                1'b0, 1'b0, EFF_CMD},
        '{8'hFF,                1'b0, 1'b1, EFF_BAD},
        '{OP_OFFSET,            1'b0, 1'b0, EFF_CMD},
        '{CTRL_CO | CTRL_DC,    1'b1, 1'b1, EFF_CTRL},
        '{8'h55,                1'b0, 1'b1, EFF_RAM},
        '{8'h00,                1'b0, 1'b1, EFF_CTRL},
        '{8'h3F,                1'b0, 1'b0, EFF_CMD},
        '{OP_END,               1'b0, 1'b0, EFF_CMD},
        '{OP_END,               1'b0, 1'b0, EFF_CMD},
        '{OP_PUMP | 8'h03,      1'b0, 1'b0, EFF_CMD},
        '{OP_NOP,               1'b0, 1'b0, EFF_CMD},
        '{8'h7F,                1'b0, 1'b0, EFF_CMD},
        '{8'hC8,                1'b0, 1'b0, EFF_CMD},
        '{CTRL_DC,              1'b1, 1'b1, EFF_CTRL},
        '{8'h00,                1'b0, 1'b1, EFF_BAD}
    };

    oled_controller_command_decoder dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic decoded_t decode_byte(input logic [7:0] b, input logic opens);
        decoded_t r;
        logic [2:0] wpage;
        logic [7:0] wcol;
        wpage = page_q;
        wcol = col_q;
        r.data = 8'h00;
        if (opens || need_control)
        begin
            co_single = b[7];
            data_stream = b[6];
            need_control = 1'b0;
            r.effect = EFF_CTRL;
        end
        else
        begin
            r.effect = EFF_CMD;
            if (data_stream)
            begin
                if (col_q >= COLUMNS)
                begin
                    r.effect = EFF_BAD;
                end
                else
                begin
                    r.data = b;
                    r.effect = EFF_RAM;
                    if (col_q < COLUMNS - 1)
                        col_q = col_q + 8'd1;
                end
            end
            else if (held_arg)
            begin
                held_arg = 1'b0;
                case (held_op)
                    OP_CONTRAST: contrast_q = b;
                    OP_MUX:      mux_q = b[5:0];
                    OP_DCDC:     mode_q[F_DCDC] = b[0];
                    OP_OFFSET:   offset_q = b[5:0];
                    OP_CLOCK:    clock_q = b;
                    OP_CHARGE:   charge_q = b;
                    OP_COMPINS:  mode_q[F_COMALT] = b[4];
                    default:     vcom_q = b;
                endcase
            end
            else if (b[7:4] == 4'h0)
                col_q[3:0] = b[3:0];
            else if (b[7:4] == 4'h1)
                col_q[7:4] = b[3:0];
            else if (b[7:2] == OP_PUMP[7:2])
                mode_q[9:8] = b[1:0];
            else if (b[7:6] == 2'b01)
                start_q = b[5:0];
            else if (b[7:3] == OP_PAGE[7:3])
                page_q = (b[2:0] >= PAGES) ? LAST_PAGE : b[2:0];
            else if (b[7:4] == 4'hC)
                mode_q[F_COMREV] = b[3];
            else if (b[7:1] == OP_SEG0[7:1])
                mode_q[F_SEG] = b[0];
            else if (b[7:1] == OP_ALLON0[7:1])
                mode_q[F_ALLON] = b[0];
            else if (b[7:1] == OP_NORMAL[7:1])
                mode_q[F_INV] = b[0];
            else if (b[7:1] == OP_OFF[7:1])
                mode_q[F_ON] = b[0];
            else
            begin
                case (b)
                    OP_CONTRAST, OP_MUX, OP_DCDC, OP_OFFSET,
                    OP_CLOCK, OP_CHARGE, OP_COMPINS, OP_VCOM:
                    begin
                        held_op = b;
                        held_arg = 1'b1;
                    end
                    OP_RMW:
                    begin
                        col_saved = col_q;
                        mode_q[F_RMW] = 1'b1;
                    end
                    OP_END:
                    begin
                        if (mode_q[F_RMW])
                        begin
                            col_q = col_saved;
                            mode_q[F_RMW] = 1'b0;
                        end
                    end
                    OP_NOP: ;
                    default: r.effect = EFF_BAD;
                endcase
            end
            if (co_single)
                need_control = 1'b1;
        end
        if (r.effect != EFF_RAM)
        begin
            wpage = page_q;
            wcol = col_q;
        end
        r.page = wpage;
        r.column = wcol;
        r.contrast = contrast_q;
        r.start = start_q;
        r.offset = offset_q;
        r.mux = mux_q;
        r.mode = mode_q;
        r.clock = clock_q;
        r.charge = charge_q;
        r.vcom = vcom_q;
        return r;
    endfunction

    function automatic logic [7:0] next_command();
        cmd_pick_t pick;
        logic [7:0] c;
        if (arg_due)
        begin
            arg_due = 1'b0;
            return 8'($urandom_range(0, 255));
        end
        pick = cmd_pick_t'($urandom_range(0, PICK_GAP));
        case (pick)
            PICK_COL_LO: c = {4'h0, 4'($urandom_range(0, 15))};
            PICK_COL_HI: c = {4'h1, 4'($urandom_range(0, 8))};
            PICK_PUMP:   c = OP_PUMP | 8'($urandom_range(0, 3));
            PICK_START:  c = {2'b01, 6'($urandom_range(0, 63))};
            PICK_DOUBLE:
            begin
                c = arg_ops[$urandom_range(0, 7)];
                arg_due = 1'b1;
            end
            PICK_MODE:   c = mode_ops[$urandom_range(0, 7)];
            PICK_PAGE:   c = OP_PAGE | 8'($urandom_range(0, 7));
            PICK_SCAN:   c = {4'hC, 4'($urandom_range(0, 15))};
            PICK_RMW:    c = rmw_ops[$urandom_range(0, 2)];
            PICK_ANY:    c = 8'($urandom_range(0, 255));
            default:     c = 8'($urandom_range(8'h20, 8'h3F));
        endcase
        return c;
    endfunction

    task automatic send_item(input logic [7:0] code, input logic opens,
                             input logic pinned, input effect_t pinned_eff);
        decoded_t want;
        while (gap_left > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            gap_left--;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        bus_byte <= code;
        first_byte <= opens;
        do
            @(posedge clk);
        while (in_stall);
        want = decode_byte(code, opens);
        if (pinned)
            want.effect = pinned_eff;
        results_due.push_back(want);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        decoded_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("result item with nothing expected");
                errors++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("effect", want.effect, effect);
                check_field("ram_page", want.page, ram_page);
                check_field("ram_column", want.column, ram_column);
                check_field("ram_data", want.data, ram_data);
                check_field("contrast_level", want.contrast, contrast_level);
                check_field("start_line", want.start, start_line);
                check_field("display_offset", want.offset, display_offset);
                check_field("mux_ratio", want.mux, mux_ratio);
                check_field("mode_flags", want.mode, mode_flags);
                check_field("clock_setting", want.clock, clock_setting);
                check_field("charge_periods", want.charge, charge_periods);
                check_field("vcom_level", want.vcom, vcom_level);
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        static int hold_left = 0;
        static int mode_left = 0;
        static int tick = 0;
        static stall_mode_t stall_mode = STALL_NONE;
        tick++;
        if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left <= 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, STALL_PERIODIC));
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
                default:      out_stall <= (tick % 4 == 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("oled_controller_command_decoder_tb: errors");
            $finish;
        end
    end

    initial
    begin
        int pick;
        int n;
        logic dc;
        logic held;
        logic drained;
        rst_n = 1'b0;
        in_valid = 1'b0;
        bus_byte = 8'h00;
        first_byte = 1'b0;
        errors = 0;
        cycle_count = 0;
        items_sent = 0;
        burst_left = 1;
        gap_left = 0;
        hold_asked = 0;
        hold_served = 0;
        arg_due = 1'b0;
        held = 1'b0;
        drained = 1'b0;

        need_control = 1'b1;
        data_stream = 1'b0;
        co_single = 1'b0;
        held_op = 8'h00;
        held_arg = 1'b0;
        page_q = 3'd0;
        col_q = 8'h00;
        col_saved = 8'h00;
        contrast_q = RST_CONTRAST;
        start_q = 6'd0;
        offset_q = 6'd0;
        mux_q = RST_MUX;
        mode_q = RST_MODE;
        clock_q = RST_CLOCK;
        charge_q = RST_CHARGE;
        vcom_q = RST_VCOM;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].code, directed_rows[i].opens,
                      directed_rows[i].pinned, directed_rows[i].eff);

        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            if (!held && items_sent > 300)
            begin
                held = 1'b1;
                hold_asked++;
            end
            if (!drained && items_sent > 600)
            begin
                drained = 1'b1;
                @(negedge clk);
                in_valid <= 1'b0;
                while (results_due.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                send_item({2'b00, 6'($urandom_range(0, 63))}, 1'b1, 1'b0, EFF_CTRL);
                n = $urandom_range(1, 16);
                repeat (n) send_item(next_command(), 1'b0, 1'b0, EFF_CTRL);
            end
            else if (pick < 65)
            begin
                // place the column before the data burst
                if ($urandom_range(0, 9) < 7)
                begin
                    send_item({2'b00, 6'($urandom_range(0, 63))}, 1'b1, 1'b0, EFF_CTRL);
                    send_item({4'h1, 4'($urandom_range(0, 8))}, 1'b0, 1'b0, EFF_CTRL);
                    send_item({4'h0, 4'($urandom_range(0, 15))}, 1'b0, 1'b0, EFF_CTRL);
                end
                send_item({2'b01, 6'($urandom_range(0, 63))}, 1'b1, 1'b0, EFF_CTRL);
                n = $urandom_range(1, 24);
                repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, EFF_CTRL);
            end
            else if (pick < 85)
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                begin
                    dc = ($urandom_range(0, 2) == 0);
                    send_item({1'b1, dc, 6'($urandom_range(0, 63))},
                              (i == 0) || ($urandom_range(0, 9) == 0), 1'b0, EFF_CTRL);
                    send_item(dc ? 8'($urandom_range(0, 255)) : next_command(),
                              1'b0, 1'b0, EFF_CTRL);
                end
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_item(8'($urandom_range(0, 255)),
                                     ($urandom_range(0, 7) == 0), 1'b0, EFF_CTRL);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("oled_controller_command_decoder_tb: clean");
        else
            $display("oled_controller_command_decoder_tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/oledcd_pkg.sv
hw/rtl/oled_controller_command_decoder.sv
dv/oled_controller_command_decoder_tb.sv
